/* rtl/srp_pkg.sv */
// ----------------------------------------------------------------------------
// srp_pkg
// shared widths, codes and controller/datapath signal groups for the
// sector read-ahead prefetcher
// ----------------------------------------------------------------------------
package srp_pkg;

    localparam int ADDR_W      = 20;
    localparam int SLOT_W      = 8;
    localparam int CNT_W       = 8;
    localparam int RING_SLOTS  = 256;
    localparam int LANES       = 8;
    localparam int LANE_W      = 3;
    localparam int ROWS        = RING_SLOTS / LANES;
    localparam int ROW_W       = SLOT_W - LANE_W;
    localparam int MAX_AHEAD   = 16;
    localparam int BURST_LIMIT = 2;
    localparam int COUNT_MAX   = 255;

    typedef enum logic [1:0] {
        REQ_TICK   = 2'd0,
        REQ_HINT   = 2'd1,
        REQ_TRAY   = 2'd2,
        REQ_LOOKUP = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APPLY,
        ST_FETCH,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic capture;
        logic apply;
        logic fetch;
        logic scan_rd;
        logic scan_cmp;
        logic scan_next;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic req_lookup;
        logic scan_hit;
        logic scan_last;
        logic out_free;
    } t_dp_sts;

endpackage

/* rtl/srp_req_if.sv */
// ----------------------------------------------------------------------------
// srp_req_if
// request channel: tick, read hint, tray change or lookup
// ----------------------------------------------------------------------------
interface srp_req_if;
    logic                       valid;
    logic                       ready;
    logic [1:0]                 req_type;
    logic [srp_pkg::ADDR_W-1:0] sector_addr;
    logic                       eject_flag;

    modport source (output valid, output req_type, output sector_addr, output eject_flag,
                    input ready);
    modport sink   (input valid, input req_type, input sector_addr, input eject_flag,
                    output ready);
endinterface

/* rtl/srp_rsp_if.sv */
// ----------------------------------------------------------------------------
// srp_rsp_if
// response channel: fetch issue and lookup result
// ----------------------------------------------------------------------------
interface srp_rsp_if;
    logic                       valid;
    logic                       ready;
    logic                       fetch_valid;
    logic [srp_pkg::ADDR_W-1:0] fetch_addr;
    logic [srp_pkg::SLOT_W-1:0] fetch_slot;
    logic                       hit;
    logic [srp_pkg::SLOT_W-1:0] hit_slot;
    logic                       in_range;

    modport source (output valid, output fetch_valid, output fetch_addr, output fetch_slot,
                    output hit, output hit_slot, output in_range, input ready);
    modport sink   (input valid, input fetch_valid, input fetch_addr, input fetch_slot,
                    input hit, input hit_slot, input in_range, output ready);
endinterface

/* rtl/srp_cfg_if.sv */
// ----------------------------------------------------------------------------
// srp_cfg_if
// configuration write channel for the lead-out sector register
// ----------------------------------------------------------------------------
interface srp_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [srp_pkg::ADDR_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/srp_ctrl.sv */
// ----------------------------------------------------------------------------
// srp_ctrl
// sequencing fsm: capture, prefetch update and fetch, or row-wise tag scan
// ----------------------------------------------------------------------------
module srp_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  srp_pkg::t_dp_sts i_sts,
    output srp_pkg::t_dp_cmd o_cmd
);

    srp_pkg::t_state r_state;
    srp_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= srp_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            srp_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = i_sts.req_lookup ? srp_pkg::ST_SCAN_RD : srp_pkg::ST_APPLY;
                end
            end
            srp_pkg::ST_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state     = srp_pkg::ST_FETCH;
            end
            srp_pkg::ST_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = srp_pkg::ST_DONE;
            end
            srp_pkg::ST_SCAN_RD: begin
                o_cmd.scan_rd = 1'b1;
                n_state       = srp_pkg::ST_SCAN_CMP;
            end
            srp_pkg::ST_SCAN_CMP: begin
                o_cmd.scan_cmp = 1'b1;
                if (i_sts.scan_hit || i_sts.scan_last) begin
                    n_state = srp_pkg::ST_DONE;
                end else begin
                    o_cmd.scan_next = 1'b1;
                    n_state         = srp_pkg::ST_SCAN_RD;
                end
            end
            srp_pkg::ST_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = srp_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = srp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/srp_dp.sv */
// ----------------------------------------------------------------------------
// srp_dp
// prefetch window registers, slot valid bits, banked tag memory, lookup
// compare and the output register
// ----------------------------------------------------------------------------
module srp_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [srp_pkg::ADDR_W-1:0] i_cfg_data,
    input  logic [1:0]                 i_req_type,
    input  logic [srp_pkg::ADDR_W-1:0] i_sector_addr,
    input  logic                       i_eject_flag,
    input  logic                       i_out_ready,
    input  srp_pkg::t_dp_cmd           i_cmd,
    output srp_pkg::t_dp_sts           o_sts,
    output logic                       o_valid,
    output logic                       o_fetch_valid,
    output logic [srp_pkg::ADDR_W-1:0] o_fetch_addr,
    output logic [srp_pkg::SLOT_W-1:0] o_fetch_slot,
    output logic                       o_hit,
    output logic [srp_pkg::SLOT_W-1:0] o_hit_slot,
    output logic                       o_in_range
);

    localparam int AW = srp_pkg::ADDR_W;
    localparam int SW = srp_pkg::SLOT_W;
    localparam int CW = srp_pkg::CNT_W;
    localparam int LN = srp_pkg::LANES;
    localparam int LW = srp_pkg::LANE_W;
    localparam int RW = srp_pkg::ROW_W;
    localparam logic signed [AW:0] AHEAD_LIM  = (AW+1)'(srp_pkg::MAX_AHEAD);
    localparam logic signed [AW:0] AHEAD_P1   = (AW+1)'(srp_pkg::MAX_AHEAD + 1);
    localparam logic signed [AW:0] BURST_EDGE =
        (AW+1)'(srp_pkg::MAX_AHEAD + 1 - srp_pkg::BURST_LIMIT);
    localparam logic [CW-1:0]      BURST      = CW'(srp_pkg::BURST_LIMIT);
    localparam logic [CW-1:0]      CNT_MAX    = CW'(srp_pkg::COUNT_MAX);
    localparam logic [RW-1:0]      LAST_ROW   = RW'(srp_pkg::ROWS - 1);

    // configuration and prefetch state
    logic [AW-1:0]                 r_lead;
    logic [AW-1:0]                 r_paddr;
    logic [CW-1:0]                 r_pcnt;
    logic [AW-1:0]                 r_last;
    logic                          r_known;
    logic [SW-1:0]                 r_wslot;
    logic                          r_ejected;
    logic [srp_pkg::RING_SLOTS-1:0] r_valid;

    // tag memory, one bank per lane
    logic [AW-1:0]                 r_tag_mem [LN][srp_pkg::ROWS];
    logic [AW-1:0]                 r_rd_tag  [LN];
    logic [LN-1:0]                 r_rd_vld;

    // captured item and scan row
    srp_pkg::t_req                 r_type;
    logic [AW-1:0]                 r_addr;
    logic                          r_ej;
    logic [RW-1:0]                 r_row;

    // pending result
    logic                          r_res_fv;
    logic [AW-1:0]                 r_res_fa;
    logic [SW-1:0]                 r_res_fs;
    logic                          r_res_hit;
    logic [SW-1:0]                 r_res_hs;
    logic                          r_res_rng;

    // output register
    logic                          r_o_valid;
    logic                          r_o_fv;
    logic [AW-1:0]                 r_o_fa;
    logic [SW-1:0]                 r_o_fs;
    logic                          r_o_hit;
    logic [SW-1:0]                 r_o_hs;
    logic                          r_o_rng;

    // update logic
    logic                          n_seq;
    logic signed [AW:0]            n_ahead;
    logic signed [AW:0]            n_room;
    logic [AW-1:0]                 n_paddr;
    logic [CW-1:0]                 n_pcnt;
    logic                          n_clear;
    logic [LN-1:0]                 n_match;
    logic [LW-1:0]                 n_lane;
    logic [SW-1:0]                 n_row_base;

    assign n_row_base = {r_row, {LW{1'b0}}};

    always_comb begin
        n_seq   = r_known && ({1'b0, r_addr} == ({1'b0, r_last} + (AW+1)'(1)));
        n_ahead = $signed({1'b0, r_paddr}) - $signed({1'b0, r_addr});
        n_room  = AHEAD_P1 - n_ahead;
        n_paddr = r_paddr;
        n_pcnt  = r_pcnt;
        n_clear = 1'b0;
        case (r_type)
            srp_pkg::REQ_HINT: begin
                if (n_seq) begin
                    if (n_ahead <= AHEAD_LIM) begin
                        n_pcnt = (n_ahead > BURST_EDGE) ? n_room[CW-1:0] : BURST;
                    end else if (r_pcnt != CNT_MAX) begin
                        n_pcnt = r_pcnt + CW'(1);
                    end
                end else if (!r_known || r_addr != r_last) begin
                    n_paddr = r_addr;
                    n_pcnt  = CW'(1);
                end
            end
            srp_pkg::REQ_TRAY: begin
                if (r_ej != r_ejected) begin
                    n_clear = 1'b1;
                    n_paddr = '0;
                    n_pcnt  = '0;
                end
            end
            default: begin
            end
        endcase
        if (n_pcnt != '0 && n_paddr == r_lead) begin
            n_pcnt = '0;
        end
    end

    always_comb begin
        n_lane = '0;
        for (int l = 0; l < LN; l++) begin
            n_match[l] = r_rd_vld[l] && (r_rd_tag[l] == r_addr);
        end
        for (int l = LN - 1; l >= 0; l--) begin
            if (n_match[l]) begin
                n_lane = LW'(l);
            end
        end
    end

    assign o_sts.req_lookup = (i_req_type == srp_pkg::REQ_LOOKUP);
    assign o_sts.scan_hit   = |n_match;
    assign o_sts.scan_last  = (r_row == LAST_ROW);
    assign o_sts.out_free   = !r_o_valid || i_out_ready;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead    <= '0;
            r_paddr   <= '0;
            r_pcnt    <= '0;
            r_last    <= '0;
            r_known   <= 1'b0;
            r_wslot   <= '0;
            r_ejected <= 1'b0;
            r_valid   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_lead <= i_cfg_data;
            end
            if (i_cmd.apply) begin
                r_paddr <= n_paddr;
                r_pcnt  <= n_pcnt;
                if (r_type == srp_pkg::REQ_HINT) begin
                    r_last  <= r_addr;
                    r_known <= 1'b1;
                end
                if (n_clear) begin
                    r_ejected <= r_ej;
                    r_wslot   <= '0;
                    r_last    <= '0;
                    r_known   <= 1'b0;
                    r_valid   <= '0;
                end
            end
            if (i_cmd.fetch && r_pcnt != '0) begin
                r_valid[r_wslot] <= 1'b1;
                r_wslot          <= r_wslot + SW'(1);
                r_paddr          <= r_paddr + AW'(1);
                r_pcnt           <= r_pcnt - CW'(1);
            end
            if (i_cmd.load_out) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // tag memory write and row read
    always_ff @(posedge i_clk) begin
        if (i_cmd.fetch && r_pcnt != '0) begin
            r_tag_mem[r_wslot[LW-1:0]][r_wslot[SW-1:LW]] <= r_paddr;
        end
        if (i_cmd.scan_rd) begin
            for (int l = 0; l < LN; l++) begin
                r_rd_tag[l] <= r_tag_mem[l][r_row];
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_rd) begin
            r_rd_vld <= r_valid[n_row_base +: LN];
        end
        if (i_cmd.capture) begin
            r_type    <= srp_pkg::t_req'(i_req_type);
            r_addr    <= i_sector_addr;
            r_ej      <= i_eject_flag;
            r_row     <= '0;
            r_res_fv  <= 1'b0;
            r_res_fa  <= '0;
            r_res_fs  <= '0;
            r_res_hit <= 1'b0;
            r_res_hs  <= '0;
            r_res_rng <= (i_req_type == srp_pkg::REQ_LOOKUP) && (i_sector_addr < r_lead);
        end
        if (i_cmd.scan_next) begin
            r_row <= r_row + RW'(1);
        end
        if (i_cmd.fetch && r_pcnt != '0) begin
            r_res_fv <= 1'b1;
            r_res_fa <= r_paddr;
            r_res_fs <= r_wslot;
        end
        if (i_cmd.scan_cmp && (|n_match)) begin
            r_res_hit <= 1'b1;
            r_res_hs  <= {r_row, n_lane};
        end
        if (i_cmd.load_out) begin
            r_o_fv  <= r_res_fv;
            r_o_fa  <= r_res_fa;
            r_o_fs  <= r_res_fs;
            r_o_hit <= r_res_hit;
            r_o_hs  <= r_res_hs;
            r_o_rng <= r_res_rng;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_fetch_valid = r_o_fv;
    assign o_fetch_addr  = r_o_fa;
    assign o_fetch_slot  = r_o_fs;
    assign o_hit         = r_o_hit;
    assign o_hit_slot    = r_o_hs;
    assign o_in_range    = r_o_rng;

endmodule

/* rtl/sector_readahead_prefetcher.sv */
// tick, hint and tray change: apply, then fetch, then done loads the result once the output is free
// lookup: each tag row of 8 slots is read and then compared; the scan ends at the first hit or last row
// one item in flight; the next transfer is taken once done has loaded the result and the fsm is idle,
// while the previous result may still wait in the output register
// reset clears prefetch state, slot valid bits, lead-out and the output valid bit;
// no clearing pass, tags are only read behind their valid bits
// ----------------------------------------------------------------------------
// sector_readahead_prefetcher
// read-ahead controller for a ring of disc sector slots
// ----------------------------------------------------------------------------
module sector_readahead_prefetcher (
    input  logic      i_clk,
    input  logic      i_rst_n,
    srp_req_if.sink   i_req,
    srp_rsp_if.source o_rsp,
    srp_cfg_if.sink   i_cfg
);

    srp_pkg::t_dp_cmd w_cmd;
    srp_pkg::t_dp_sts w_sts;
    logic             w_in_ready;

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = w_in_ready;

    srp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    srp_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg.valid),
        .i_cfg_data    (i_cfg.data),
        .i_req_type    (i_req.req_type),
        .i_sector_addr (i_req.sector_addr),
        .i_eject_flag  (i_req.eject_flag),
        .i_out_ready   (o_rsp.ready),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .o_valid       (o_rsp.valid),
        .o_fetch_valid (o_rsp.fetch_valid),
        .o_fetch_addr  (o_rsp.fetch_addr),
        .o_fetch_slot  (o_rsp.fetch_slot),
        .o_hit         (o_rsp.hit),
        .o_hit_slot    (o_rsp.hit_slot),
        .o_in_range    (o_rsp.in_range)
    );

endmodule
